// ----- rtl/core/pla_pkg.sv -----
// Shared constants for the point light accumulator.
package pla_pkg;
    localparam int unsigned COORD_W = 24;
    localparam int unsigned COLOR_W = 16;
    localparam int unsigned STR_W   = 16;
    localparam int unsigned SUM_W   = 20;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned D2_W    = 52;
    localparam int unsigned ROOT_W  = 26;
    localparam int unsigned NUM_W   = 38;
    localparam int unsigned DEN_W   = 20;
    localparam int unsigned FAC_W   = 13;
    localparam logic [FAC_W-1:0] ONE_POINT_SIX = 13'd6554;
    localparam logic [SUM_W-1:0] WHITE = 20'd4096;
    localparam logic [SUM_W-1:0] SUM_MAX = 20'hFFFFF;
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_SHADE = 1'b1;
endpackage

// ----- rtl/core/point_light_accumulator_unit.sv -----
// Top level of the point light accumulator: light table and shading sequencer.
//  channel | signals                                   | handshake
//  request | i_req_type .. i_strength                  | start & !busy
//  result  | o_sum_red/green/blue, o_clipped           | o_done strobe, one cycle
//  config  | i_cfg_data                                | i_cfg_valid & o_cfg_ready
// A write request is taken while idle, busy stays low. A shade request holds busy while, per
// light in use, it steps fetch, squares, root, divide, factor, mac, step, skipping mac when
// the factor is not positive, squares to mac at zero strength; o_done pulses as busy falls.
// One shared 26x26 multiplier serves squares and color scaling; root and divide are
// one bit per cycle. Reset is synchronous, active low; no clearing pass. Results
// cannot be stalled.
module point_light_accumulator_unit #(
    parameter int unsigned LIGHTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [3:0]  i_light_slot,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [23:0] i_pos_z,
    input  logic [15:0] i_color_red,
    input  logic [15:0] i_color_green,
    input  logic [15:0] i_color_blue,
    input  logic [15:0] i_strength,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    output logic        o_done,
    output logic [19:0] o_sum_red,
    output logic [19:0] o_sum_green,
    output logic [19:0] o_sum_blue,
    output logic        o_clipped
);
    localparam int unsigned IDX_W = (LIGHTS > 1) ? $clog2(LIGHTS) : 1;
    localparam int unsigned LCNT_W = $clog2(LIGHTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_FETCH, S_LOAD, S_SQX, S_SQY, S_SQZ, S_ROOT, S_DIV,
        S_FAC, S_MR, S_MG, S_MB, S_NEXT, S_DONE
    } t_state;

    t_state r_state;
    logic [pla_pkg::CNT_W-1:0] r_cfg;
    logic [pla_pkg::COORD_W-1:0] m_x [LIGHTS];
    logic [pla_pkg::COORD_W-1:0] m_y [LIGHTS];
    logic [pla_pkg::COORD_W-1:0] m_z [LIGHTS];
    logic [47:0] m_rgb [LIGHTS];
    logic [pla_pkg::STR_W-1:0] m_str [LIGHTS];

    logic [pla_pkg::COORD_W-1:0] r_lx, r_ly, r_lz;
    logic [47:0] r_rgb;
    logic [pla_pkg::STR_W-1:0] r_str;
    logic signed [pla_pkg::COORD_W-1:0] r_px, r_py, r_pz;
    logic [LCNT_W-1:0] r_idx, r_count;
    logic [25:0] r_ax, r_ay, r_az;
    logic [pla_pkg::D2_W-1:0] r_d2, r_rem_n;
    logic [pla_pkg::ROOT_W-1:0] r_root;
    logic [pla_pkg::ROOT_W+1:0] r_rrem;
    logic [5:0] r_step;
    logic [pla_pkg::NUM_W-1:0] r_num;
    logic [pla_pkg::DEN_W:0] r_drem;
    logic [pla_pkg::DEN_W-1:0] r_den;
    logic [pla_pkg::NUM_W-1:0] r_quot;
    logic [pla_pkg::FAC_W-1:0] r_fac;
    logic [pla_pkg::SUM_W-1:0] r_r, r_g, r_b;
    logic r_clip;

    logic [25:0] mul_a, mul_b;
    logic [51:0] mul_p;
    assign mul_p = mul_a * mul_b;

    always_comb begin
        mul_a = 26'(r_fac);
        mul_b = 26'(r_rgb[47:32]);
        case (r_state)
            S_SQX:   begin mul_a = r_ax; mul_b = r_ax; end
            S_SQY:   begin mul_a = r_ay; mul_b = r_ay; end
            S_SQZ:   begin mul_a = r_az; mul_b = r_az; end
            S_MG:    mul_b = 26'(r_rgb[31:16]);
            S_MB:    mul_b = 26'(r_rgb[15:0]);
            default: mul_b = 26'(r_rgb[47:32]);
        endcase
    end

    function automatic logic [25:0] absdiff(input logic signed [23:0] a,
                                            input logic signed [23:0] b);
        logic signed [25:0] d;
        d = 26'(a) - 26'(b);
        return d[25] ? 26'(-d) : d;
    endfunction

    logic [20:0] add_r;
    logic [pla_pkg::SUM_W:0] add_s;
    logic [pla_pkg::SUM_W-1:0] add_in;
    logic [pla_pkg::ROOT_W+1:0] rt_try;
    logic [pla_pkg::ROOT_W+1:0] rt_rem;
    logic [pla_pkg::DEN_W:0] dv_rem;
    logic [LCNT_W-1:0] lim;
    logic [IDX_W-1:0] wr_idx;

    always_comb begin
        add_in = (r_state == S_MG) ? r_g : (r_state == S_MB) ? r_b : r_r;
        add_r = 21'(mul_p[51:12]);
        add_s = 21'(add_in) + add_r;
        rt_rem = {r_rrem[pla_pkg::ROOT_W-1:0], r_rem_n[pla_pkg::D2_W-1 -: 2]};
        rt_try = {r_root, 2'b01};
        dv_rem = {r_drem[pla_pkg::DEN_W-1:0], r_num[pla_pkg::NUM_W-1]};
        lim = (r_cfg > LCNT_W'(LIGHTS)) ? LCNT_W'(LIGHTS) : LCNT_W'(r_cfg);
    end

    assign wr_idx = IDX_W'(i_light_slot);
    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start && i_req_type == pla_pkg::REQ_WRITE
            && 32'(i_light_slot) < LIGHTS) begin
            m_x[wr_idx] <= i_pos_x;
            m_y[wr_idx] <= i_pos_y;
            m_z[wr_idx] <= i_pos_z;
            m_rgb[wr_idx] <= {i_color_red, i_color_green, i_color_blue};
            m_str[wr_idx] <= i_strength;
        end
        if (r_state == S_FETCH) begin
            r_lx <= m_x[r_idx[IDX_W-1:0]];
            r_ly <= m_y[r_idx[IDX_W-1:0]];
            r_lz <= m_z[r_idx[IDX_W-1:0]];
            r_rgb <= m_rgb[r_idx[IDX_W-1:0]];
            r_str <= m_str[r_idx[IDX_W-1:0]];
        end
    end

    // saturating add of one channel product into its sum
    task automatic mac_update();
        logic [pla_pkg::SUM_W-1:0] v;
        v = add_s[pla_pkg::SUM_W] ? pla_pkg::SUM_MAX : add_s[pla_pkg::SUM_W-1:0];
        if (add_s[pla_pkg::SUM_W]) r_clip <= 1'b1;
        if (r_state == S_MR) r_r <= v;
        else if (r_state == S_MG) r_g <= v;
        else r_b <= v;
    endtask

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) r_cfg <= i_cfg_data;
            case (r_state)
                S_IDLE: if (start && i_req_type == pla_pkg::REQ_SHADE) begin
                    r_px <= i_pos_x; r_py <= i_pos_y; r_pz <= i_pos_z;
                    r_r <= '0; r_g <= '0; r_b <= '0; r_clip <= 1'b0;
                    r_idx <= '0; r_count <= lim;
                    if (lim == '0) begin
                        r_r <= pla_pkg::WHITE; r_g <= pla_pkg::WHITE;
                        r_b <= pla_pkg::WHITE;
                        r_state <= S_DONE;
                    end else r_state <= S_FETCH;
                end
                S_FETCH: r_state <= S_LOAD;
                S_LOAD: begin
                    r_ax <= absdiff(r_px, r_lx);
                    r_ay <= absdiff(r_py, r_ly);
                    r_az <= absdiff(r_pz, r_lz);
                    r_state <= (r_str == '0) ? S_NEXT : S_SQX;
                end
                S_SQX: begin r_d2 <= mul_p; r_state <= S_SQY; end
                S_SQY: begin r_d2 <= r_d2 + mul_p; r_state <= S_SQZ; end
                S_SQZ: begin
                    r_rem_n <= r_d2 + mul_p;
                    r_rrem <= '0; r_root <= '0; r_step <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_rem_n <= r_rem_n << 2;
                    if (rt_rem >= rt_try) begin
                        r_rrem <= rt_rem - rt_try;
                        r_root <= {r_root[pla_pkg::ROOT_W-2:0], 1'b1};
                    end else begin
                        r_rrem <= rt_rem;
                        r_root <= {r_root[pla_pkg::ROOT_W-2:0], 1'b0};
                    end
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'(pla_pkg::ROOT_W - 1)) begin
                        r_state <= S_DIV;
                        r_step <= '0;
                        r_drem <= '0;
                        r_quot <= '0;
                        r_den <= 20'(r_str) * 20'd10;
                    end
                end
                S_DIV: begin
                    if (r_step == '0) r_num <= {r_root, 12'd0};
                    else begin
                        r_num <= r_num << 1;
                        if (dv_rem >= {1'b0, r_den}) begin
                            r_drem <= dv_rem - {1'b0, r_den};
                            r_quot <= {r_quot[pla_pkg::NUM_W-2:0], 1'b1};
                        end else begin
                            r_drem <= dv_rem;
                            r_quot <= {r_quot[pla_pkg::NUM_W-2:0], 1'b0};
                        end
                    end
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'(pla_pkg::NUM_W)) r_state <= S_FAC;
                end
                S_FAC: begin
                    if (r_quot >= pla_pkg::NUM_W'(pla_pkg::ONE_POINT_SIX))
                        r_state <= S_NEXT;
                    else begin
                        r_fac <= pla_pkg::ONE_POINT_SIX - r_quot[pla_pkg::FAC_W-1:0];
                        r_state <= S_MR;
                    end
                end
                S_MR, S_MG, S_MB, S_NEXT: begin
                    if (r_state != S_NEXT) begin
                        mac_update();
                    end
                    r_state <= (r_state == S_MR) ? S_MG :
                               (r_state == S_MG) ? S_MB :
                               (r_state == S_MB) ? S_NEXT :
                               ((r_idx + LCNT_W'(1) == r_count) ? S_DONE : S_FETCH);
                    if (r_state == S_NEXT) r_idx <= r_idx + LCNT_W'(1);
                end
                S_DONE: begin
                    o_done <= 1'b1;
                    o_sum_red <= r_r; o_sum_green <= r_g; o_sum_blue <= r_b;
                    o_clipped <= r_clip;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("done while busy");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FETCH |-> r_idx < r_count) else $error("index past count");
`endif
endmodule
